// ===== rtl/skht_pkg.sv =====
// Package for the string key hash table: status and command codes, FSM state
// types and fixed constants. No dependencies.
`timescale 1ns / 1ps
package skht_pkg;

  localparam int unsigned KeyWords   = 4;
  localparam int unsigned LenWidth   = 6;
  localparam int unsigned ValueWidth = 16;
  localparam logic [63:0] DjbSeed    = 64'd5381;
  localparam int unsigned DjbShift   = 5;
  localparam int unsigned FillNum    = 3;
  localparam int unsigned FillDen    = 4;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_DONE
  } tbl_state_e;

  typedef enum logic [2:0] {
    H_IDLE,
    H_BYTES,
    H_FOLD,
    H_QUOT,
    H_REM,
    H_FIX
  } hash_state_e;

  // Handshake between the table controller and the hash unit.
  typedef struct packed {
    logic start;
  } hash_ctl_t;

  typedef struct packed {
    logic                done;
    logic [LenWidth-1:0] len;
  } hash_sts_t;

endpackage

// ===== rtl/skht_if.sv =====
// Request and response channel interfaces of the string key hash table.
// Depends on skht_pkg for field widths.
`timescale 1ns / 1ps
interface skht_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [skht_pkg::LenWidth-1:0] key_length;
  logic [63:0]                   key_bytes_0_7;
  logic [63:0]                   key_bytes_8_15;
  logic [63:0]                   key_bytes_16_23;
  logic [63:0]                   key_bytes_24_31;
  logic [skht_pkg::ValueWidth-1:0] value_in;

  modport source (output valid, cmd, key_length, key_bytes_0_7, key_bytes_8_15,
                  key_bytes_16_23, key_bytes_24_31, value_in, input ready);
  modport sink (input valid, cmd, key_length, key_bytes_0_7, key_bytes_8_15,
                key_bytes_16_23, key_bytes_24_31, value_in, output ready);
endinterface

interface skht_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [skht_pkg::ValueWidth-1:0] value_out;

  modport source (output valid, status, value_out, input ready);
  modport sink (input valid, status, value_out, output ready);
endinterface

// ===== rtl/skht_store.sv =====
// Slot store: one synchronous single-port-write, single-read memory holding
// the used mark, key length, key bytes and value of each slot. No dependencies.
`timescale 1ns / 1ps
module skht_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 279
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/skht_hash.sv =====
// Hash unit: cleans the key one byte a cycle while running djb2, then reduces
// the 64-bit hash modulo the slot count in a few fixed steps. Depends on skht_pkg.
`timescale 1ns / 1ps
module skht_hash #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned KEY_BYTES   = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  skht_pkg::hash_ctl_t                ctl_i,
  input  logic [KEY_BYTES*8-1:0]             key_i,
  input  logic [skht_pkg::LenWidth-1:0]      len_i,
  output skht_pkg::hash_sts_t                sts_o,
  output logic [$clog2(TABLE_SLOTS)-1:0]     home_o,
  output logic [KEY_BYTES*8-1:0]             key_o
);
  import skht_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam int unsigned RW = IW + 1;
  localparam int unsigned BW = $clog2(KEY_BYTES);
  localparam int unsigned AW = IW + 11;

  // Weight of hash byte j: 2^(8j) modulo the slot count.
  function automatic logic [7:0][IW-1:0] weight_table();
    logic [7:0][IW-1:0] t;
    logic [63:0]        w;
    w = 64'd1;
    for (int j = 0; j < 8; j++) begin
      t[j] = IW'(w);
      w = (w << 8) % 64'(TABLE_SLOTS);
    end
    return t;
  endfunction

  localparam logic [7:0][IW-1:0] Weights = weight_table();
  localparam logic [32:0]        Recip   = 33'((64'd1 << 32) / 64'(TABLE_SLOTS));

  hash_state_e          hst_q, hst_d;
  logic [LenWidth-1:0]  n_q, n_d, lim_q, lim_d;
  logic [63:0]          h_q, h_d;
  logic [2:0]           j_q, j_d;
  logic [AW-1:0]        acc_q, acc_d, quot_q, quot_d, prod_qm;
  logic [RW-1:0]        rem_q, rem_d;
  logic                 done_q, done_d;
  logic [KEY_BYTES-1:0][7:0] key_q, key_d;
  logic [7:0]           cur_byte, fold_byte;
  logic                 take_byte;
  logic [IW+7:0]        fold_term;
  logic [AW+32:0]       quot_full;

  assign cur_byte  = key_q[n_q[BW-1:0]];
  assign take_byte = (n_q < lim_q) && (cur_byte != 8'd0);

  // The sum of weighted bytes is below 2^(IW+11), so the reciprocal estimate of
  // the quotient is at most one short and one correction step suffices.
  assign fold_byte = h_q[{j_q, 3'b000} +: 8];
  assign fold_term = {{IW{1'b0}}, fold_byte} * {8'd0, Weights[j_q]};
  assign quot_full = {33'd0, acc_q} * {{AW{1'b0}}, Recip};
  assign prod_qm   = quot_q * AW'(TABLE_SLOTS);

  always_comb begin
    hst_d = hst_q;
    unique case (hst_q)
      H_IDLE:  if (ctl_i.start) hst_d = H_BYTES;
      H_BYTES: if (!take_byte) hst_d = H_FOLD;
      H_FOLD:  if (j_q == 3'd7) hst_d = H_QUOT;
      H_QUOT:  hst_d = H_REM;
      H_REM:   hst_d = H_FIX;
      H_FIX:   hst_d = H_IDLE;
      default: hst_d = H_IDLE;
    endcase
  end

  always_comb begin
    n_d    = n_q;
    lim_d  = lim_q;
    h_d    = h_q;
    j_d    = j_q;
    acc_d  = acc_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    key_d  = key_q;
    done_d = 1'b0;
    unique case (hst_q)
      H_IDLE: begin
        if (ctl_i.start) begin
          key_d = key_i;
          lim_d = (len_i > LenWidth'(KEY_BYTES)) ? LenWidth'(KEY_BYTES) : len_i;
          n_d   = '0;
          h_d   = DjbSeed;
        end
      end
      H_BYTES: begin
        if (take_byte) begin
          h_d = (h_q << DjbShift) + h_q + {56'd0, cur_byte};
          n_d = n_q + LenWidth'(1);
        end else begin
          j_d   = '0;
          acc_d = '0;
        end
      end
      H_FOLD: begin
        acc_d = acc_q + AW'(fold_term);
        j_d   = j_q + 3'd1;
      end
      H_QUOT: quot_d = quot_full[32 +: AW];
      H_REM:  rem_d  = RW'(acc_q - prod_qm);
      H_FIX: begin
        rem_d  = (rem_q >= RW'(TABLE_SLOTS)) ? rem_q - RW'(TABLE_SLOTS) : rem_q;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hst_q  <= H_IDLE;
      done_q <= 1'b0;
    end else begin
      hst_q  <= hst_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    lim_q  <= lim_d;
    h_q    <= h_d;
    j_q    <= j_d;
    acc_q  <= acc_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    key_q  <= key_d;
  end

  // Bytes past the effective length are stored and compared as zero.
  always_comb begin
    for (int k = 0; k < KEY_BYTES; k++) begin
      key_o[k*8 +: 8] = (LenWidth'(k) < n_q) ? key_q[k] : 8'd0;
    end
  end

  assign home_o     = rem_q[IW-1:0];
  assign sts_o.done = done_q;
  assign sts_o.len  = n_q;

endmodule

// ===== rtl/string_key_hash_table.sv =====
// Top level of the string key hash table: request register, probe controller
// and result register. Depends on skht_pkg, skht_if, skht_hash and skht_store.
//
// Usage: requests arrive on req_i (insert or lookup of a key of up to
// KEY_BYTES bytes), one result per request leaves on rsp_o. Both channels
// move an item when valid and ready are high at a rising edge.
// One request is worked on at a time. It walks the key bytes (one hashed byte
// per cycle), reduces the 64-bit hash modulo TABLE_SLOTS (eight weighted byte
// sums, a reciprocal multiply, a multiply-subtract and a final correction),
// then probes slots, each with a memory read and then a compare or write
// back, and hands the result to the output register. At least one slot is
// probed, except for an insert refused by the fill count.
// After reset the block runs a clearing pass over every slot of the slot
// store to drop every used mark; req_i.ready stays low during it.
// A finished result sits in an output register; a new request is accepted
// while it waits, but its own result is held until rsp_o is taken.
`timescale 1ns / 1ps
module string_key_hash_table #(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned KEY_BYTES   = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skht_req_if.sink   req_i,
  skht_rsp_if.source rsp_o
);
  import skht_pkg::*;

  localparam int unsigned IW    = $clog2(TABLE_SLOTS);
  localparam int unsigned CW    = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned KW    = KEY_BYTES * 8;
  localparam int unsigned EW    = 1 + LenWidth + KW + ValueWidth;
  localparam int unsigned Limit = TABLE_SLOTS * FillNum / FillDen;

  tbl_state_e state_q, state_d;
  logic [IW-1:0] clr_q, clr_d, probe_q, probe_d, steps_q, steps_d;
  logic [CW-1:0] count_q, count_d;
  logic          cmd_q, cmd_d;
  logic [ValueWidth-1:0] val_in_q, val_in_d;
  logic [KW-1:0]         key_raw_q, key_raw_d;
  logic [LenWidth-1:0]   len_raw_q, len_raw_d;
  status_e               res_stat_q, res_stat_d;
  logic [ValueWidth-1:0] res_val_q, res_val_d;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_stat_q, out_stat_d;
  logic [ValueWidth-1:0] out_val_q, out_val_d;

  hash_ctl_t     hctl;
  hash_sts_t     hsts;
  logic [IW-1:0] home;
  logic [KW-1:0] key_clean;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic                  r_used, r_match, last_step, in_acc, out_free;
  logic [LenWidth-1:0]   r_len;
  logic [KW-1:0]         r_key;
  logic [ValueWidth-1:0] r_val;
  logic [255:0]          key_all;

  assign key_all = {req_i.key_bytes_24_31, req_i.key_bytes_16_23,
                    req_i.key_bytes_8_15, req_i.key_bytes_0_7};

  assign r_used  = rdata[EW-1];
  assign r_len   = rdata[EW-2 -: LenWidth];
  assign r_key   = rdata[ValueWidth +: KW];
  assign r_val   = rdata[ValueWidth-1:0];
  assign r_match = r_used && (r_len == hsts.len) && (r_key == key_clean);
  assign last_step = (steps_q == IW'(TABLE_SLOTS - 1));
  assign out_free  = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;

  // The hash unit latches the key at the accepting edge, together with start.
  skht_hash #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_BYTES  (KEY_BYTES)
  ) u_hash (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (hctl),
    .key_i (key_raw_d),
    .len_i (len_raw_d),
    .sts_o (hsts),
    .home_o(home),
    .key_o (key_clean)
  );

  skht_store #(
    .DEPTH(TABLE_SLOTS),
    .WIDTH(EW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == IW'(TABLE_SLOTS - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = S_HASH;
      S_HASH: begin
        if (hsts.done) begin
          if (cmd_q == CMD_INSERT && count_q >= CW'(Limit)) state_d = S_DONE;
          else state_d = S_PROBE_RD;
        end
      end
      S_PROBE_RD: state_d = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (cmd_q == CMD_INSERT) begin
          if (!r_used || last_step) state_d = S_DONE;
          else state_d = S_PROBE_RD;
        end else begin
          if (!r_used || r_match || last_step) state_d = S_DONE;
          else state_d = S_PROBE_RD;
        end
      end
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    clr_d       = clr_q;
    probe_d     = probe_q;
    steps_d     = steps_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    val_in_d    = val_in_q;
    key_raw_d   = key_raw_q;
    len_raw_d   = len_raw_q;
    res_stat_d  = res_stat_q;
    res_val_d   = res_val_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_stat_d  = out_stat_q;
    out_val_d   = out_val_q;
    hctl.start  = 1'b0;
    we          = 1'b0;
    waddr       = probe_q;
    wdata       = {1'b1, hsts.len, key_clean, val_in_q};
    re          = 1'b0;
    raddr       = probe_q;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + IW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_d      = req_i.cmd;
          val_in_d   = req_i.value_in;
          key_raw_d  = key_all[KW-1:0];
          len_raw_d  = req_i.key_length;
          hctl.start = 1'b1;
        end
      end
      S_HASH: begin
        if (hsts.done) begin
          probe_d   = home;
          steps_d   = '0;
          res_stat_d = STAT_FULL;
          res_val_d = '0;
        end
      end
      S_PROBE_RD: re = 1'b1;
      S_PROBE_CHK: begin
        probe_d = (probe_q == IW'(TABLE_SLOTS - 1)) ? '0 : probe_q + IW'(1);
        steps_d = steps_q + IW'(1);
        if (cmd_q == CMD_INSERT) begin
          if (!r_used) begin
            we         = 1'b1;
            count_d    = count_q + CW'(1);
            res_stat_d = STAT_OK;
          end else begin
            res_stat_d = STAT_FULL;
          end
        end else begin
          if (r_match) begin
            res_stat_d = STAT_OK;
            res_val_d  = r_val;
          end else begin
            res_stat_d = STAT_MISS;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_val_d   = res_val_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q    <= probe_d;
    steps_q    <= steps_d;
    cmd_q      <= cmd_d;
    val_in_q   <= val_in_d;
    key_raw_q  <= key_raw_d;
    len_raw_q  <= len_raw_d;
    res_stat_q <= res_stat_d;
    res_val_q  <= res_val_d;
    out_stat_q <= out_stat_d;
    out_val_q  <= out_val_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_stat_q;
  assign rsp_o.value_out = out_val_q;

endmodule
